@@ design/jslsg_pkg.sv @@
// ----------------------------------------------------------------------------
// jslsg_pkg: shared types and constants for the joint slew limiter
// Widths, register indexes, reset values and the structs that carry
// configuration and queued items between the front and back parts.
// ----------------------------------------------------------------------------
package jslsg_pkg;

  localparam int JOINTS     = 5;
  localparam int ANGLE_W    = 16;
  localparam int COUNT_W    = 8;
  localparam int STEP_W     = 15;
  localparam int CENTER_W   = 10;
  localparam int GOAL_W     = 10;
  localparam int FRAC_W     = 16;
  localparam int SUM_W      = 30;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Servo counts per radian in Q12.4, about 1024 / (2 pi).
  localparam int SCALE_Q16 = 2608;
  localparam int GOAL_MAX  = 1023;

  // Reset values of the configuration registers.
  localparam logic [STEP_W-1:0]   STEP_RESET     = 15'd61;
  localparam logic [STEP_W-1:0]   DEADBAND_RESET = 15'd82;
  localparam logic [CENTER_W-1:0] CENTER_RESET   = 10'd512;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGN_MASK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_0   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_3   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_4   = 3'd7;

  typedef logic [ANGLE_W-1:0]               angle_t;
  typedef angle_t [JOINTS-1:0]              angle_vec_t;
  typedef logic [CENTER_W-1:0]              center_t;
  typedef logic [GOAL_W-1:0]                goal_t;
  typedef goal_t [JOINTS-1:0]               goal_vec_t;

  // Settings used by the front part.
  typedef struct packed {
    logic [STEP_W-1:0] step_limit;
    logic [STEP_W-1:0] deadband;
  } front_cfg_t;

  // Settings used by the back part.
  typedef struct packed {
    logic [JOINTS-1:0]        sign_mask;
    center_t [JOINTS-1:0]     center;
  } back_cfg_t;

  // Queue handshake status between front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ design/jslsg_front.sv @@
// ----------------------------------------------------------------------------
// jslsg_front: message filter, deadband and slew-rate limiter
// Drops short messages, primes the stored angles on the first message and
// moves each joint from its previous angle by at most the step limit.
// ----------------------------------------------------------------------------
module jslsg_front import jslsg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  angle_vec_t         angle,
  input  logic [COUNT_W-1:0] position_count,
  input  front_cfg_t         cfg,
  output logic               push,
  output angle_vec_t         limited
);

  angle_vec_t previous_angle;
  angle_vec_t previous_angle_next;
  logic       primed;
  logic       keep;

  // Messages with fewer positions than joints are dropped.
  assign keep = accept && (position_count >= COUNT_W'(JOINTS));
  assign push = keep;

  // Per joint: deadband on joint zero, then clamp the change to the step.
  always_comb begin
    logic signed [ANGLE_W-1:0] prev;
    logic signed [ANGLE_W-1:0] tgt;
    logic signed [ANGLE_W:0]   mag;
    logic signed [ANGLE_W:0]   diff;
    logic signed [ANGLE_W:0]   step_pos;
    logic signed [ANGLE_W:0]   step_neg;
    logic signed [ANGLE_W:0]   lim;
    for (int j = 0; j < JOINTS; j++) begin
      tgt  = $signed(angle[j]);
      prev = primed ? $signed(previous_angle[j]) : tgt;
      if (j == 0) begin
        mag = tgt[ANGLE_W-1] ? -{tgt[ANGLE_W-1], tgt} : {tgt[ANGLE_W-1], tgt};
        if (mag < $signed({{(ANGLE_W+1-STEP_W){1'b0}}, cfg.deadband})) begin
          tgt = '0;
        end
      end
      diff     = {tgt[ANGLE_W-1], tgt} - {prev[ANGLE_W-1], prev};
      step_pos = $signed({{(ANGLE_W+1-STEP_W){1'b0}}, cfg.step_limit});
      step_neg = -step_pos;
      if (diff > step_pos) begin
        diff = step_pos;
      end else if (diff < step_neg) begin
        diff = step_neg;
      end
      lim = {prev[ANGLE_W-1], prev} + diff;
      limited[j]             = lim[ANGLE_W-1:0];
      previous_angle_next[j] = lim[ANGLE_W-1:0];
    end
  end

  // Stored angles and the primed flag change only on a kept message.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_angle <= '0;
      primed         <= 1'b0;
    end else if (keep) begin
      previous_angle <= previous_angle_next;
      primed         <= 1'b1;
    end
  end

endmodule

@@ design/jslsg_queue.sv @@
// ----------------------------------------------------------------------------
// jslsg_queue: two-entry queue of limited angle sets
// Decouples the front part from the back part so each can stall on its own.
// ----------------------------------------------------------------------------
module jslsg_queue import jslsg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  angle_vec_t    push_data,
  input  logic          pop,
  output angle_vec_t    head,
  output queue_status_t status
);

  angle_vec_t  mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign head         = mem[rd_ptr];

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ design/jslsg_back.sv @@
// ----------------------------------------------------------------------------
// jslsg_back: scaling to servo counts
// Applies the joint sign, scales by the counts-per-radian constant, adds
// the center, then rounds and clamps into a registered output stage.
// ----------------------------------------------------------------------------
module jslsg_back import jslsg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  queue_status_t qstat,
  input  angle_vec_t    head,
  input  back_cfg_t     cfg,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output goal_vec_t     goal
);

  localparam int PAD_W = SUM_W - CENTER_W - FRAC_W;

  logic                           s1_valid;
  logic signed [SUM_W-1:0]        sum [JOINTS];
  logic signed [SUM_W-1:0]        sum_next [JOINTS];
  goal_vec_t                      goal_next;
  logic                           out_ready;
  logic                           s1_ready;

  // Ready chain from the output back to the queue.
  assign out_ready = !out_valid || !out_stall;
  assign s1_ready  = !s1_valid || out_ready;
  assign pop       = !qstat.empty && s1_ready;

  // Stage one: signed multiply by the scale and add the center.
  always_comb begin
    logic signed [ANGLE_W:0] s;
    logic signed [SUM_W-1:0] prod;
    for (int j = 0; j < JOINTS; j++) begin
      s = {head[j][ANGLE_W-1], head[j]};
      if (cfg.sign_mask[j]) begin
        s = -s;
      end
      prod        = SUM_W'(s) * $signed(SUM_W'(SCALE_Q16));
      sum_next[j] = $signed({{PAD_W{1'b0}}, cfg.center[j], {FRAC_W{1'b0}}}) + prod;
    end
  end

  // Stage two: round half away from zero, then clamp to the goal range.
  always_comb begin
    logic [SUM_W-1:0]        rnd;
    logic [SUM_W-FRAC_W-1:0] r;
    for (int j = 0; j < JOINTS; j++) begin
      rnd = sum[j] + SUM_W'(1 << (FRAC_W - 1));
      r   = rnd[SUM_W-1:FRAC_W];
      if (sum[j][SUM_W-1]) begin
        goal_next[j] = '0;
      end else if (r > (SUM_W-FRAC_W)'(GOAL_MAX)) begin
        goal_next[j] = GOAL_W'(GOAL_MAX);
      end else begin
        goal_next[j] = r[GOAL_W-1:0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      sum <= sum_next;
    end
    if (out_ready) begin
      goal <= goal_next;
    end
  end

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= pop;
      end
      if (out_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

endmodule

@@ design/joint_slew_limit_servo_goal.sv @@
// ----------------------------------------------------------------------------
// joint_slew_limit_servo_goal: slew-limited servo goals for five joints
// Top level: configuration registers, front limiter, queue and back scaler.
// ----------------------------------------------------------------------------
// Usage:
// An input transfer carries five joint angles (signed Q3.12 radians) and a
// position count; it completes when in_valid is high and in_stall is low.
// Messages with fewer than five positions are absorbed and give no result.
// Every other message gives one output transfer of five goal counts,
// completed when out_valid is high and out_stall is low.
// The limited angles enter the queue at the input transfer; the scaling
// multiply is then registered in stage one and the rounding and clamp in
// the output register, which drives out_valid. One message can be taken
// every cycle while the queue is not full; the stored previous angles are
// updated once per kept message.
// When the receiver stalls, the output register and the scaling stage hold,
// the two-entry queue fills, and in_stall rises once it is full.
// Reset clears the stored angles and the primed flag, empties the queue and
// loads the register defaults: step 61, deadband 82, no sign inversion,
// centers at 512. The user writes the registers, through cfg_write, cfg_index
// and cfg_data, only with no message in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module joint_slew_limit_servo_goal import jslsg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [ANGLE_W-1:0] angle_0,
  input  logic signed [ANGLE_W-1:0] angle_1,
  input  logic signed [ANGLE_W-1:0] angle_2,
  input  logic signed [ANGLE_W-1:0] angle_3,
  input  logic signed [ANGLE_W-1:0] angle_4,
  input  logic [COUNT_W-1:0]    position_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [GOAL_W-1:0]     goal_0,
  output logic [GOAL_W-1:0]     goal_1,
  output logic [GOAL_W-1:0]     goal_2,
  output logic [GOAL_W-1:0]     goal_3,
  output logic [GOAL_W-1:0]     goal_4
);

  front_cfg_t    front_cfg;
  back_cfg_t     back_cfg;
  angle_vec_t    angle;
  angle_vec_t    limited;
  angle_vec_t    head;
  goal_vec_t     goal;
  queue_status_t qstat;
  logic          accept;
  logic          push;
  logic          pop;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_cfg.step_limit <= STEP_RESET;
      front_cfg.deadband   <= DEADBAND_RESET;
      back_cfg.sign_mask   <= '0;
      for (int j = 0; j < JOINTS; j++) begin
        back_cfg.center[j] <= CENTER_RESET;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STEP_LIMIT: front_cfg.step_limit <= cfg_data[STEP_W-1:0];
        REG_DEADBAND:   front_cfg.deadband   <= cfg_data[STEP_W-1:0];
        REG_SIGN_MASK:  back_cfg.sign_mask   <= cfg_data[JOINTS-1:0];
        REG_CENTER_0:   back_cfg.center[0]   <= cfg_data[CENTER_W-1:0];
        REG_CENTER_1:   back_cfg.center[1]   <= cfg_data[CENTER_W-1:0];
        REG_CENTER_2:   back_cfg.center[2]   <= cfg_data[CENTER_W-1:0];
        REG_CENTER_3:   back_cfg.center[3]   <= cfg_data[CENTER_W-1:0];
        REG_CENTER_4:   back_cfg.center[4]   <= cfg_data[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  // Input transfer completes whenever the queue has room.
  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  assign angle[0] = angle_0;
  assign angle[1] = angle_1;
  assign angle[2] = angle_2;
  assign angle[3] = angle_3;
  assign angle[4] = angle_4;

  jslsg_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .angle          (angle),
    .position_count (position_count),
    .cfg            (front_cfg),
    .push           (push),
    .limited        (limited)
  );

  jslsg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (limited),
    .pop       (pop),
    .head      (head),
    .status    (qstat)
  );

  jslsg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .head      (head),
    .cfg       (back_cfg),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .goal      (goal)
  );

  assign goal_0 = goal[0];
  assign goal_1 = goal[1];
  assign goal_2 = goal[2];
  assign goal_3 = goal[3];
  assign goal_4 = goal[4];

endmodule
